// ===== sv/blr_pkg.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer package
// Glyph codes and the command and status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package blr_pkg;

  localparam logic [1:0] GLYPH_FULL   = 2'd0;
  localparam logic [1:0] GLYPH_UPPER  = 2'd1;
  localparam logic [1:0] GLYPH_LOWER  = 2'd2;
  localparam logic [1:0] GLYPH_UNUSED = 2'd3;

  typedef struct packed {
    logic load;
    logic step;
  } blr_cmd_t;

  typedef struct packed {
    logic at_end;
  } blr_status_t;

endpackage

// ===== sv/blr_seg_if.sv =====
// ----------------------------------------------------------------------------
// Segment channel
// Valid/ready channel carrying one line segment per transaction.
// ----------------------------------------------------------------------------
interface blr_seg_if #(
  parameter int COORD_WIDTH = 6
);
  logic                   valid;
  logic                   ready;
  logic [COORD_WIDTH-1:0] start_x;
  logic [COORD_WIDTH-1:0] start_y;
  logic [COORD_WIDTH-1:0] end_x;
  logic [COORD_WIDTH-1:0] end_y;
  logic [1:0]             glyph_kind;

  modport source (output valid, start_x, start_y, end_x, end_y, glyph_kind,
                  input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, glyph_kind,
                output ready);
endinterface

// ===== sv/blr_pt_if.sv =====
// ----------------------------------------------------------------------------
// Point channel
// Valid/ready channel carrying one rasterised grid point per transaction.
// ----------------------------------------------------------------------------
interface blr_pt_if #(
  parameter int COORD_WIDTH = 6
);
  logic                   valid;
  logic                   ready;
  logic [COORD_WIDTH-1:0] point_x;
  logic [COORD_WIDTH-1:0] point_y;
  logic [1:0]             point_glyph;
  logic                   last_point;

  modport source (output valid, point_x, point_y, point_glyph, last_point,
                  input ready);
  modport sink (input valid, point_x, point_y, point_glyph, last_point,
                output ready);
endinterface

// ===== sv/bresenham_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// Bresenham line rasterizer
// Walks a line segment in any octant and emits each of its grid points.
// ----------------------------------------------------------------------------
// Each transaction on in_i carries one segment: start point, end point and
// a glyph kind, where the unused code three is delivered as a full block.
// The segment is taken only while the block is idle; the cycle after it is
// taken the start point appears on out_o. Each point transaction on out_o
// lets the next point appear in the following cycle, so a segment of longer
// span s is delivered as s + 1 transactions, and the block is ready for the
// next segment in the cycle after the end point, which carries last_point,
// has been taken. When the receiver stalls, the current point is held
// unchanged and the walk pauses. Reset returns the block to idle with no
// point pending.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer #(
  parameter int COORD_WIDTH = 6
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  blr_seg_if.sink   in_i,
  blr_pt_if.source  out_o
);
  import blr_pkg::*;

  blr_cmd_t    cmd;
  blr_status_t status;

  blr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  blr_dp #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .start_x_i     (in_i.start_x),
    .start_y_i     (in_i.start_y),
    .end_x_i       (in_i.end_x),
    .end_y_i       (in_i.end_y),
    .glyph_kind_i  (in_i.glyph_kind),
    .point_x_o     (out_o.point_x),
    .point_y_o     (out_o.point_y),
    .point_glyph_o (out_o.point_glyph)
  );

  assign out_o.last_point = status.at_end;

endmodule

// ===== sv/blr_dp.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer datapath
// Holds the current point, end point, spans, directions and error term, and
// advances one Bresenham step on command.
// ----------------------------------------------------------------------------
module blr_dp #(
  parameter int COORD_WIDTH = 6
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  blr_pkg::blr_cmd_t      cmd_i,
  output blr_pkg::blr_status_t   status_o,
  input  logic [COORD_WIDTH-1:0] start_x_i,
  input  logic [COORD_WIDTH-1:0] start_y_i,
  input  logic [COORD_WIDTH-1:0] end_x_i,
  input  logic [COORD_WIDTH-1:0] end_y_i,
  input  logic [1:0]             glyph_kind_i,
  output logic [COORD_WIDTH-1:0] point_x_o,
  output logic [COORD_WIDTH-1:0] point_y_o,
  output logic [1:0]             point_glyph_o
);
  import blr_pkg::*;

  localparam int ErrWidth = COORD_WIDTH + 3;

  logic [COORD_WIDTH-1:0]     cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [COORD_WIDTH-1:0]     target_x_q, target_x_d, target_y_q, target_y_d;
  logic [COORD_WIDTH-1:0]     span_x_q, span_x_d, span_y_q, span_y_d;
  logic                       dir_x_neg_q, dir_x_neg_d, dir_y_neg_q, dir_y_neg_d;
  logic [1:0]                 glyph_q, glyph_d;
  logic signed [ErrWidth-1:0] err_q, err_d;

  logic signed [ErrWidth-1:0] ex, ey, twice, ld_ex, ld_ey;
  logic [COORD_WIDTH-1:0]     ld_span_x, ld_span_y;
  logic                       ld_neg_x, ld_neg_y, step_x, step_y;

  always_comb begin
    ld_neg_x  = !(start_x_i < end_x_i);
    ld_neg_y  = !(start_y_i < end_y_i);
    ld_span_x = ld_neg_x ? start_x_i - end_x_i : end_x_i - start_x_i;
    ld_span_y = ld_neg_y ? start_y_i - end_y_i : end_y_i - start_y_i;
    ld_ex     = signed'({3'b000, ld_span_x});
    ld_ey     = signed'({3'b000, ld_span_y});

    ex     = signed'({3'b000, span_x_q});
    ey     = signed'({3'b000, span_y_q});
    twice  = err_q <<< 1;
    step_x = twice > -ey;
    step_y = twice < ex;

    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    target_x_d  = target_x_q;
    target_y_d  = target_y_q;
    span_x_d    = span_x_q;
    span_y_d    = span_y_q;
    dir_x_neg_d = dir_x_neg_q;
    dir_y_neg_d = dir_y_neg_q;
    glyph_d     = glyph_q;
    err_d       = err_q;

    if (cmd_i.load) begin
      cur_x_d     = start_x_i;
      cur_y_d     = start_y_i;
      target_x_d  = end_x_i;
      target_y_d  = end_y_i;
      span_x_d    = ld_span_x;
      span_y_d    = ld_span_y;
      dir_x_neg_d = ld_neg_x;
      dir_y_neg_d = ld_neg_y;
      glyph_d     = (glyph_kind_i == GLYPH_UNUSED) ? GLYPH_FULL : glyph_kind_i;
      err_d       = ld_ex - ld_ey;
    end else if (cmd_i.step) begin
      err_d = err_q - (step_x ? ey : '0) + (step_y ? ex : '0);
      if (step_x) begin
        cur_x_d = dir_x_neg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
      end
      if (step_y) begin
        cur_y_d = dir_y_neg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      target_x_q  <= '0;
      target_y_q  <= '0;
      span_x_q    <= '0;
      span_y_q    <= '0;
      dir_x_neg_q <= 1'b0;
      dir_y_neg_q <= 1'b0;
      glyph_q     <= '0;
      err_q       <= '0;
    end else begin
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      target_x_q  <= target_x_d;
      target_y_q  <= target_y_d;
      span_x_q    <= span_x_d;
      span_y_q    <= span_y_d;
      dir_x_neg_q <= dir_x_neg_d;
      dir_y_neg_q <= dir_y_neg_d;
      glyph_q     <= glyph_d;
      err_q       <= err_d;
    end
  end

  assign status_o.at_end = (cur_x_q == target_x_q) && (cur_y_q == target_y_q);
  assign point_x_o       = cur_x_q;
  assign point_y_o       = cur_y_q;
  assign point_glyph_o   = glyph_q;

endmodule

// ===== sv/blr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer controller
// Takes a segment when idle, then presents one point per cycle while the
// receiver accepts them, until the end point has been delivered.
// ----------------------------------------------------------------------------
module blr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output blr_pkg::blr_cmd_t    cmd_o,
  input  blr_pkg::blr_status_t status_i
);
  import blr_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic state_q, state_d;
  logic out_fire;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StRun);
  assign out_fire    = out_valid_o && out_ready_i;

  always_comb begin
    state_d    = state_q;
    cmd_o.load = 1'b0;
    cmd_o.step = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StRun;
        end
      end
      StRun: begin
        if (out_fire) begin
          if (status_i.at_end) begin
            state_d = StIdle;
          end else begin
            cmd_o.step = 1'b1;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== bench/bresenham_line_rasterizer_tb.sv =====
// ----------------------------------------------------------------------------
// Bresenham line rasterizer testbench
// Feeds directed and random segments through the segment channel, traces
// each accepted segment in one shared scoreboard and compares every point
// transaction with the oldest point still outstanding. Sender gaps and
// receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import blr_pkg::*;

  localparam int CW         = 6;
  localparam int NUM_RANDOM = 460;
  localparam int NUM_PHASES = 4;
  localparam int CYCLE_CAP  = 600000;

  typedef struct packed {
    logic [CW-1:0] sx;
    logic [CW-1:0] sy;
    logic [CW-1:0] ex;
    logic [CW-1:0] ey;
    logic [1:0]    glyph;
  } segment_t;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [1:0]    glyph;
    logic          last;
  } point_t;

  class point_scoreboard;
    point_t pending_points[$];
    int     errors;

    function void note_segment(segment_t seg);
      logic [CW-1:0] x, y;
      logic [1:0]    g;
      bit            x_neg, y_neg, done;
      int            span_x, span_y, err, twice, n;
      point_t        p;
      x     = seg.sx;
      y     = seg.sy;
      g     = (seg.glyph == GLYPH_UNUSED) ? GLYPH_FULL : seg.glyph;
      x_neg = !(seg.sx < seg.ex);
      y_neg = !(seg.sy < seg.ey);
      span_x = x_neg ? int'(seg.sx) - int'(seg.ex) : int'(seg.ex) - int'(seg.sx);
      span_y = y_neg ? int'(seg.sy) - int'(seg.ey) : int'(seg.ey) - int'(seg.sy);
      err = span_x - span_y;
      for (n = 0; n < (1 << CW); n++) begin
        done = (x == seg.ex) && (y == seg.ey);
        p.x     = x;
        p.y     = y;
        p.glyph = g;
        p.last  = done;
        pending_points.push_back(p);
        if (done) break;
        twice = 2 * err;
        if (twice > -span_y) begin
          err -= span_y;
          x = x_neg ? x - 1'b1 : x + 1'b1;
        end
        if (twice < span_x) begin
          err += span_x;
          y = y_neg ? y - 1'b1 : y + 1'b1;
        end
      end
    endfunction

    function void check_point(point_t got);
      point_t want;
      if (pending_points.size() == 0) begin
        errors++;
        $display("%0t: unexpected point, expected none, got x=%0d y=%0d glyph=%0d last=%0d",
                 $time, got.x, got.y, got.glyph, got.last);
        return;
      end
      want = pending_points.pop_front();
      if (want != got) begin
        errors++;
        $display("%0t: point mismatch expected x=%0d y=%0d glyph=%0d last=%0d,",
                 $time, want.x, want.y, want.glyph, want.last);
        $display("%0t:   got x=%0d y=%0d glyph=%0d last=%0d",
                 $time, got.x, got.y, got.glyph, got.last);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_gap_pct;
  int   recv_stall_pct;
  int   cycles;

  point_scoreboard sb = new();

  blr_seg_if #(.COORD_WIDTH(CW)) seg_bus ();
  blr_pt_if  #(.COORD_WIDTH(CW)) pt_bus ();

  bresenham_line_rasterizer #(.COORD_WIDTH(CW)) DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (seg_bus),
    .out_o  (pt_bus)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_CAP) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL bresenham_line_rasterizer");
    $finish;
  end

  always @(negedge clk) begin
    pt_bus.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && pt_bus.valid && pt_bus.ready)
      sb.check_point({pt_bus.point_x, pt_bus.point_y, pt_bus.point_glyph,
                      pt_bus.last_point});
  end

  task automatic send_segment(input segment_t seg);
    while ($urandom_range(99) < send_gap_pct) begin
      seg_bus.valid = 1'b0;
      @(negedge clk);
    end
    seg_bus.start_x    = seg.sx;
    seg_bus.start_y    = seg.sy;
    seg_bus.end_x      = seg.ex;
    seg_bus.end_y      = seg.ey;
    seg_bus.glyph_kind = seg.glyph;
    seg_bus.valid      = 1'b1;
    @(posedge clk);
    while (!seg_bus.ready) @(posedge clk);
    sb.note_segment(seg);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    seg_bus.valid = 1'b0;
    while (sb.pending_points.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [CW-1:0] near_coord(logic [CW-1:0] c, int reach);
    int v;
    v = int'(c) + $urandom_range(2 * reach) - reach;
    if (v < 0) v = 0;
    if (v > (1 << CW) - 1) v = (1 << CW) - 1;
    return v[CW-1:0];
  endfunction

  function automatic segment_t random_segment();
    segment_t seg;
    int       mode;
    int       d;
    mode      = $urandom_range(99);
    seg.sx    = CW'($urandom_range((1 << CW) - 1));
    seg.sy    = CW'($urandom_range((1 << CW) - 1));
    seg.glyph = 2'($urandom_range(3));
    if (mode < 60) begin
      seg.ex = near_coord(seg.sx, 8);
      seg.ey = near_coord(seg.sy, 8);
    end else if (mode < 85) begin
      seg.ex = CW'($urandom_range((1 << CW) - 1));
      seg.ey = CW'($urandom_range((1 << CW) - 1));
    end else if (mode < 90) begin
      seg.ex = CW'($urandom_range((1 << CW) - 1));
      seg.ey = seg.sy;
    end else if (mode < 95) begin
      seg.ex = seg.sx;
      seg.ey = CW'($urandom_range((1 << CW) - 1));
    end else begin
      d = $urandom_range(20);
      seg.ex = near_coord(seg.sx, d);
      seg.ey = ($urandom_range(1) != 0) ? seg.sy + (seg.ex - seg.sx)
                                        : seg.sy - (seg.ex - seg.sx);
    end
    return seg;
  endfunction

  initial begin
    segment_t directed[$];
    int       gap_by_phase[NUM_PHASES];
    int       stall_by_phase[NUM_PHASES];
    int       phase;
    int       i;

    gap_by_phase   = '{0, 48, 0, 15};
    stall_by_phase = '{0, 0, 48, 15};
    send_gap_pct   = 0;
    recv_stall_pct = 0;

    seg_bus.valid      = 1'b0;
    seg_bus.start_x    = '0;
    seg_bus.start_y    = '0;
    seg_bus.end_x      = '0;
    seg_bus.end_y      = '0;
    seg_bus.glyph_kind = GLYPH_FULL;
    rst_n              = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    directed = '{
      '{6'd0,  6'd0,  6'd0,  6'd0,  GLYPH_FULL},
      '{6'd63, 6'd63, 6'd63, 6'd63, GLYPH_UPPER},
      '{6'd0,  6'd0,  6'd63, 6'd0,  GLYPH_LOWER},
      '{6'd63, 6'd5,  6'd0,  6'd5,  GLYPH_UNUSED},
      '{6'd7,  6'd0,  6'd7,  6'd63, GLYPH_UPPER},
      '{6'd40, 6'd63, 6'd40, 6'd0,  GLYPH_LOWER},
      '{6'd0,  6'd0,  6'd63, 6'd63, GLYPH_FULL},
      '{6'd63, 6'd63, 6'd0,  6'd0,  GLYPH_UNUSED},
      '{6'd0,  6'd63, 6'd63, 6'd0,  GLYPH_UPPER},
      '{6'd63, 6'd0,  6'd0,  6'd63, GLYPH_LOWER},
      '{6'd32, 6'd32, 6'd50, 6'd40, GLYPH_FULL},
      '{6'd32, 6'd32, 6'd40, 6'd50, GLYPH_UPPER},
      '{6'd32, 6'd32, 6'd24, 6'd50, GLYPH_LOWER},
      '{6'd32, 6'd32, 6'd14, 6'd40, GLYPH_FULL},
      '{6'd32, 6'd32, 6'd14, 6'd24, GLYPH_UPPER},
      '{6'd32, 6'd32, 6'd24, 6'd14, GLYPH_LOWER},
      '{6'd32, 6'd32, 6'd40, 6'd14, GLYPH_FULL},
      '{6'd32, 6'd32, 6'd50, 6'd24, GLYPH_UNUSED},
      '{6'd0,  6'd0,  6'd1,  6'd0,  GLYPH_FULL},
      '{6'd0,  6'd0,  6'd0,  6'd1,  GLYPH_UPPER},
      '{6'd5,  6'd5,  6'd6,  6'd7,  GLYPH_LOWER},
      '{6'd63, 6'd0,  6'd0,  6'd1,  GLYPH_FULL}
    };
    foreach (directed[k]) send_segment(directed[k]);
    wait_drained();

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      send_gap_pct   = gap_by_phase[phase];
      recv_stall_pct = stall_by_phase[phase];
      for (i = 0; i < NUM_RANDOM / NUM_PHASES; i++)
        send_segment(random_segment());
      wait_drained();
    end

    recv_stall_pct = 0;
    repeat (70) @(posedge clk);
    if (sb.errors == 0 && sb.pending_points.size() == 0)
      $display("PASS bresenham_line_rasterizer");
    else
      $display("FAIL bresenham_line_rasterizer");
    $finish;
  end

endmodule
